// ----- design/jtls_pkg.sv -----
// ----------------------------------------------------------------------------
// jtls_pkg
// Shared constants, codes and types of the JSON top-level splitter.
// ----------------------------------------------------------------------------
package jtls_pkg;

	localparam int NEST_DEPTH_DEF = 32;
	localparam int MAX_PIECE_DEF  = 1024;

	localparam logic [7:0] SEP_RESET = 8'd44;

	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TOO_LONG = 2'd1;
	localparam logic [1:0] ERR_MISMATCH = 2'd2;
	localparam logic [1:0] ERR_TOO_DEEP = 2'd3;

	// One result item.
	typedef struct packed {
		logic [7:0] piece_byte;
		logic       byte_present;
		logic       piece_done;
		logic [1:0] error_code;
		logic       last_of_run;
	} result_t;

	// Shift control for the bracket stack; kind is 1 for a square bracket.
	typedef struct packed {
		logic push;
		logic pop;
		logic kind;
	} stack_ctl_t;

endpackage

// ----- design/json_top_level_splitter.sv -----
// ----------------------------------------------------------------------------
// json_top_level_splitter
// Splits a JSON text into its top-level pieces at a configurable separator.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one text byte per item, end_of_text on
// the final byte. Output channel (out_valid/out_ready): one result item per
// scanned byte, carrying a piece byte, a piece end, or an error code, with
// last_of_run on the final result caused by an input item.
// Each kept byte is held back by one input item, so it is scanned and its result
// queued when the next byte (or the end of text) is accepted. An input item
// normally yields one result and is taken every cycle while in_ready is high;
// the final byte of a text that was not outer-stripped, after a held byte,
// yields two; input waits, as the single scanner handles one byte per cycle.
// The bracket stack is a row of one-bit cells that shift on push and pop.
// A two-entry output queue lets input continue while a result waits; when
// the receiver stalls and the queue is full, in_ready drops.
// The separator register is written through sep_we/sep_wdata.
// Reset sets the separator to a comma and starts a new text.
// ----------------------------------------------------------------------------
module json_top_level_splitter #(
	parameter int NEST_DEPTH = jtls_pkg::NEST_DEPTH_DEF,
	parameter int MAX_PIECE  = jtls_pkg::MAX_PIECE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sep_we,
	input  logic [7:0] sep_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] piece_byte,
	output logic       byte_present,
	output logic       piece_done,
	output logic [1:0] error_code,
	output logic       last_of_run
);

	localparam int LVL_W = $clog2(NEST_DEPTH + 1);
	localparam int LEN_W = $clog2(MAX_PIECE + 1);

	logic [7:0]       sep_q;
	logic [7:0]       held_byte_q;
	logic             held_valid_q;
	logic [7:0]       prev_byte_q;
	logic             at_start_q;
	logic             outer_q;
	logic             inq_q;
	logic [LVL_W-1:0] level_q;
	logic [LEN_W-1:0] len_q;
	logic             err_hold_q;
	logic             pend_q;
	logic [7:0]       pend_byte_q;

	logic             in_acc;
	logic             strip_open;
	logic             outer_n;
	logic             keep;
	logic             need_b;
	logic             go_pend;
	logic             pend_fire;
	logic             restart;
	logic [7:0]       op_byte;
	logic             op_last;
	logic             op_go;
	logic             q_space;

	jtls_pkg::result_t    proc_res;
	jtls_pkg::result_t    q_din;
	jtls_pkg::result_t    q_dout;
	logic                 proc_err;
	logic                 inq_n;
	logic [LVL_W-1:0]     level_n;
	logic [LEN_W-1:0]     len_n;
	jtls_pkg::stack_ctl_t ctl_raw;
	jtls_pkg::stack_ctl_t ctl;
	logic [NEST_DEPTH-1:0] kinds;

	assign in_ready = !pend_q && q_space;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		strip_open = at_start_q && (text_byte == jtls_pkg::CH_LBRACE ||
			text_byte == jtls_pkg::CH_LBRACKET);
		outer_n    = outer_q || strip_open;
		keep       = !strip_open && !(end_of_text && outer_n);
		need_b     = keep && end_of_text;

		// A pending final byte goes first, then the held byte, then the new one.
		if (pend_q) begin
			op_byte = pend_byte_q;
			op_last = 1'b1;
			op_go   = q_space;
		end else if (held_valid_q) begin
			op_byte = held_byte_q;
			op_last = end_of_text && !keep;
			op_go   = in_acc && !err_hold_q;
		end else begin
			op_byte = text_byte;
			op_last = 1'b1;
			op_go   = in_acc && !err_hold_q && need_b;
		end

		go_pend   = in_acc && !err_hold_q && held_valid_q && need_b && !proc_err;
		pend_fire = pend_q && q_space;
		restart   = pend_fire || (in_acc && end_of_text && !go_pend);

		q_din             = proc_res;
		q_din.last_of_run = pend_q || !go_pend;

		ctl      = ctl_raw;
		ctl.push = op_go && ctl_raw.push;
		ctl.pop  = op_go && ctl_raw.pop;
	end

	jtls_proc #(
		.NEST_DEPTH(NEST_DEPTH),
		.MAX_PIECE (MAX_PIECE)
	) u_proc (
		.op_byte    (op_byte),
		.op_last    (op_last),
		.separator  (sep_q),
		.prev_byte  (prev_byte_q),
		.in_quotes  (inq_q),
		.level      (level_q),
		.length     (len_q),
		.top_kind   (kinds[0]),
		.res        (proc_res),
		.err        (proc_err),
		.in_quotes_n(inq_n),
		.level_n    (level_n),
		.length_n   (len_n),
		.stack_ctl  (ctl_raw)
	);

	for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_stack
		logic above;
		logic below;
		if (i == 0) begin : g_first
			assign above = ctl.kind;
		end else begin : g_mid
			assign above = kinds[i-1];
		end
		if (i == NEST_DEPTH - 1) begin : g_last
			assign below = 1'b0;
		end else begin : g_inner
			assign below = kinds[i+1];
		end
		jtls_stack_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.from_above(above),
			.from_below(below),
			.kind_q    (kinds[i])
		);
	end

	jtls_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (op_go),
		.din      (q_din),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.dout     (q_dout),
		.space    (q_space)
	);

	assign piece_byte   = q_dout.piece_byte;
	assign byte_present = q_dout.byte_present;
	assign piece_done   = q_dout.piece_done;
	assign error_code   = q_dout.error_code;
	assign last_of_run  = q_dout.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q        <= jtls_pkg::SEP_RESET;
			held_valid_q <= 1'b0;
			prev_byte_q  <= 8'd0;
			at_start_q   <= 1'b1;
			outer_q      <= 1'b0;
			inq_q        <= 1'b0;
			level_q      <= '0;
			len_q        <= '0;
			err_hold_q   <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			if (sep_we) begin
				sep_q <= sep_wdata;
			end

			if (op_go) begin
				prev_byte_q <= op_byte;
				inq_q       <= inq_n;
				level_q     <= level_n;
				len_q       <= len_n;
				if (proc_err) begin
					err_hold_q <= 1'b1;
				end
			end

			if (pend_fire) begin
				pend_q <= 1'b0;
			end else if (in_acc && !err_hold_q) begin
				at_start_q   <= 1'b0;
				outer_q      <= outer_n;
				pend_q       <= go_pend;
				held_valid_q <= keep && !end_of_text && !(op_go && proc_err);
			end

			// End of text: everything but the separator starts over.
			if (restart) begin
				held_valid_q <= 1'b0;
				prev_byte_q  <= 8'd0;
				at_start_q   <= 1'b1;
				outer_q      <= 1'b0;
				inq_q        <= 1'b0;
				level_q      <= '0;
				len_q        <= '0;
				err_hold_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && keep) begin
			held_byte_q <= text_byte;
			pend_byte_q <= text_byte;
		end
	end

endmodule

// ----- design/jtls_stack_cell.sv -----
// ----------------------------------------------------------------------------
// jtls_stack_cell
// One level of the bracket stack. A push takes the neighbor above, a pop the
// neighbor below, so the top of the stack always sits in the first cell.
// ----------------------------------------------------------------------------
module jtls_stack_cell (
	input  logic                 clk,
	input  jtls_pkg::stack_ctl_t ctl,
	input  logic                 from_above,
	input  logic                 from_below,
	output logic                 kind_q
);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			kind_q <= from_above;
		end else if (ctl.pop) begin
			kind_q <= from_below;
		end
	end

endmodule

// ----- design/jtls_proc.sv -----
// ----------------------------------------------------------------------------
// jtls_proc
// Scans one kept byte: quote tracking, separator detection, piece length and
// bracket checks. Produces the result item and the next scanner state.
// ----------------------------------------------------------------------------
module jtls_proc #(
	parameter int NEST_DEPTH = jtls_pkg::NEST_DEPTH_DEF,
	parameter int MAX_PIECE  = jtls_pkg::MAX_PIECE_DEF,
	localparam int LVL_W = $clog2(NEST_DEPTH + 1),
	localparam int LEN_W = $clog2(MAX_PIECE + 1)
) (
	input  logic [7:0]           op_byte,
	input  logic                 op_last,
	input  logic [7:0]           separator,
	input  logic [7:0]           prev_byte,
	input  logic                 in_quotes,
	input  logic [LVL_W-1:0]     level,
	input  logic [LEN_W-1:0]     length,
	input  logic                 top_kind,
	output jtls_pkg::result_t    res,
	output logic                 err,
	output logic                 in_quotes_n,
	output logic [LVL_W-1:0]     level_n,
	output logic [LEN_W-1:0]     length_n,
	output jtls_pkg::stack_ctl_t stack_ctl
);

	logic             is_sep;
	logic             counted;
	logic [LEN_W-1:0] len_inc;
	logic             is_open;
	logic             is_close;
	logic             is_square;
	logic [1:0]       code;

	always_comb begin
		in_quotes_n = in_quotes ^ (op_byte == jtls_pkg::CH_DQUOTE &&
			prev_byte != jtls_pkg::CH_BSLASH);
		is_sep  = !op_last && op_byte == separator && !in_quotes_n &&
			level == '0;
		counted = !is_sep && !op_last;
		len_inc = length + LEN_W'(1);
		is_open   = op_byte == jtls_pkg::CH_LBRACE || op_byte == jtls_pkg::CH_LBRACKET;
		is_close  = op_byte == jtls_pkg::CH_RBRACE || op_byte == jtls_pkg::CH_RBRACKET;
		is_square = op_byte == jtls_pkg::CH_LBRACKET || op_byte == jtls_pkg::CH_RBRACKET;

		code      = jtls_pkg::ERR_NONE;
		level_n   = level;
		stack_ctl = '{push: 1'b0, pop: 1'b0, kind: is_square};

		// Length is checked before brackets, and brackets only outside quotes.
		if (counted && len_inc >= LEN_W'(MAX_PIECE)) begin
			code = jtls_pkg::ERR_TOO_LONG;
		end else if (!in_quotes_n && is_open) begin
			if (level >= LVL_W'(NEST_DEPTH)) begin
				code = jtls_pkg::ERR_TOO_DEEP;
			end else begin
				stack_ctl.push = 1'b1;
				level_n        = level + LVL_W'(1);
			end
		end else if (!in_quotes_n && is_close) begin
			if (level == '0) begin
				code = jtls_pkg::ERR_MISMATCH;
			end else begin
				stack_ctl.pop = 1'b1;
				level_n       = level - LVL_W'(1);
				if (top_kind != is_square) begin
					code = jtls_pkg::ERR_MISMATCH;
				end
			end
		end

		err = code != jtls_pkg::ERR_NONE;

		if (err) begin
			res = '{piece_byte: 8'd0, byte_present: 1'b0, piece_done: 1'b1,
				error_code: code, last_of_run: 1'b0};
		end else begin
			res = '{piece_byte: is_sep ? 8'd0 : op_byte, byte_present: !is_sep,
				piece_done: is_sep || op_last, error_code: jtls_pkg::ERR_NONE,
				last_of_run: 1'b0};
		end

		if (is_sep || op_last) begin
			length_n = '0;
		end else if (counted) begin
			length_n = len_inc;
		end else begin
			length_n = length;
		end
	end

endmodule

// ----- design/jtls_out_q.sv -----
// ----------------------------------------------------------------------------
// jtls_out_q
// Two-entry result queue that decouples the scanner from the receiver.
// ----------------------------------------------------------------------------
module jtls_out_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jtls_pkg::result_t din,
	input  logic              out_ready,
	output logic              out_valid,
	output jtls_pkg::result_t dout,
	output logic              space
);

	jtls_pkg::result_t e0_q;
	jtls_pkg::result_t e1_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign out_valid = cnt_q != 2'd0;
	assign dout      = e0_q;
	assign pop       = out_valid && out_ready;
	assign space     = cnt_q != 2'd2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e0_q <= e1_q;
		end
		if (push) begin
			if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
				e0_q <= din;
			end else if (cnt_q == 2'd1 || pop) begin
				e1_q <= din;
			end
		end
	end

endmodule
